>>> sv/pti_pkg.sv
// Shared types and constants of the periodic table interpolator.
package pti_pkg;

    localparam int TABLE_DEPTH = 16;

    // Configuration port: byte address width and register index.
    localparam int         ADDR_W         = 3;
    localparam logic [0:0] REG_IDX_POINTS = 1'b0;
    localparam logic [4:0] POINTS_RESET   = 5'd2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_ZERO_PERIOD  = 2'd1;
    localparam logic [1:0] ST_ZERO_SEGMENT = 2'd2;

    localparam logic [6:0] DIV_SHORT_STEPS = 7'd32;
    localparam logic [6:0] DIV_LONG_STEPS  = 7'd64;

    // The interpolation step is clamped to 2^34 before it is added.
    localparam logic [34:0]        Q_LIMIT = 35'h4_0000_0000;
    localparam logic signed [35:0] SAT_MAX = 36'sh0_7FFF_FFFF;
    localparam logic signed [35:0] SAT_MIN = -36'sh0_8000_0000;

    typedef struct packed {
        logic               kind;
        logic [3:0]         entry_index;
        logic [31:0]        entry_time;
        logic signed [31:0] entry_value;
        logic [31:0]        elapsed_time;
    } t_pti_in;

    typedef struct packed {
        logic signed [31:0] heat_load;
        logic [1:0]         status;
        logic [3:0]         segment;
    } t_pti_out;

    typedef struct packed {
        logic        start;
        logic        long_op;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
        logic [31:0] remainder;
    } t_div_rsp;

endpackage

>>> sv/pti_table.sv
// Breakpoint memory: one write port and one registered read port.
module pti_table #(
    parameter int P_TABLE_DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(P_TABLE_DEPTH)-1:0] i_waddr,
    input  logic [31:0]                      i_wtime,
    input  logic [31:0]                      i_wvalue,
    input  logic [$clog2(P_TABLE_DEPTH)-1:0] i_raddr,
    output logic [31:0]                      o_rd_time,
    output logic [31:0]                      o_rd_value
);

    logic [31:0] r_times  [P_TABLE_DEPTH];
    logic [31:0] r_values [P_TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_times[i_waddr]  <= i_wtime;
            r_values[i_waddr] <= i_wvalue;
        end
        o_rd_time  <= r_times[i_raddr];
        o_rd_value <= r_values[i_raddr];
    end

endmodule

>>> sv/pti_div.sv
// Restoring divider, one quotient bit per cycle, shared by modulo and interpolation.
module pti_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pti_pkg::t_div_req  i_req,
    output pti_pkg::t_div_rsp  o_rsp
);
    import pti_pkg::*;

    logic [31:0] r_rem;
    logic [63:0] r_quo;
    logic [31:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [32:0] trial;
    logic        fits;

    // Shift the next dividend bit into the partial remainder and try the subtract.
    assign trial = {r_rem, r_quo[63]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.long_op ? DIV_LONG_STEPS : DIV_SHORT_STEPS;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_den  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= fits ? 32'(trial - {1'b0, r_den}) : trial[31:0];
                r_quo <= {r_quo[62:0], fits};
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_den))
        else $error("divider remainder reached the divisor");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy)
        else $error("divider did not start");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (!r_busy && r_cnt == 7'd0))
        else $error("divider done while still iterating");

endmodule

>>> sv/periodic_table_interpolator_top.sv
// Top level of the periodic table interpolator: command port, register port and sequencer.
//
//  Channel  | Signals                               | Transfer condition
//  ---------+---------------------------------------+-----------------------------------
//  command  | start, busy, i_cmd (t_pti_in)         | start high while busy is low
//  result   | o_done, o_result (t_pti_out)          | o_done high for one cycle
//  register | psel penable pwrite paddr pwdata      | psel, penable, pwrite, pready high
//           | prdata pready                         |
//
// A table write item completes in the cycle it is taken and never raises busy. A query
// reads the period and takes the residual of the elapsed time on the shared divider;
// it then searches the segments, each search step a table read state and a compare
// state, reads both breakpoints, multiplies, and uses the divider again for the
// interpolation quotient. A zero-period query answers from the period check without the
// divider, and a zero-length segment answers once its breakpoints are read. The result is
// shown for exactly one cycle on o_done; the receiver cannot stall it. Reset is
// synchronous and active low; it clears the kept segment to zero and the point count to
// two, and the table stays undefined until written.
module periodic_table_interpolator_top #(
    parameter int P_TABLE_DEPTH = pti_pkg::TABLE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  pti_pkg::t_pti_in            i_cmd,
    output logic                        o_done,
    output pti_pkg::t_pti_out           o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pti_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import pti_pkg::*;

    localparam int IW = $clog2(P_TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_PER_RD, S_PER_CHK, S_MOD, S_SEG_RD, S_SEG_CHK, S_WALK_RD, S_WALK_CHK,
        S_LO_RD, S_HI_RD, S_HI_CAP, S_PREP, S_MUL, S_DIV, S_DIVW, S_FIN
    } t_state;

    t_state      r_state;
    logic        r_busy;
    logic [4:0]  r_points;
    logic [IW-1:0] r_seg;
    logic [31:0] r_elapsed;
    logic [31:0] r_resid;
    logic [31:0] r_tlo, r_thi, r_vlo, r_vhi;
    logic [31:0] r_nmag, r_dmag;
    logic        r_neg;
    logic [63:0] r_prod;
    logic [34:0] r_q;
    t_div_req    r_div_req;
    t_pti_out    r_result;
    logic        r_done;

    t_div_rsp    div_rsp;
    logic [31:0] rd_time, rd_value;
    logic [IW-1:0] rd_addr;

    // Clamp the configured point count to between two and the table size.
    logic [31:0] pts_w;
    logic [IW:0] n_pts;
    logic [IW:0] last_w;
    logic [IW-1:0] last_seg, last_pt, seg_nx;
    logic [31:0] seg_w;

    always_comb begin
        pts_w = 32'(r_points);
        if (pts_w < 32'd2) begin
            pts_w = 32'd2;
        end
        if (pts_w > 32'(P_TABLE_DEPTH)) begin
            pts_w = 32'(P_TABLE_DEPTH);
        end
    end

    assign n_pts    = pts_w[IW:0];
    assign last_w   = n_pts - (IW+1)'(2);
    assign last_seg = last_w[IW-1:0];
    assign last_pt  = IW'(n_pts - (IW+1)'(1));
    assign seg_nx   = IW'(r_seg + 1'b1);
    assign seg_w    = 32'(r_seg);

    // Table writes go straight into the memory in the cycle the command transfers.
    logic        cmd_take;
    logic        tbl_we;
    logic [31:0] widx_w;

    assign cmd_take = start && !r_busy;
    assign widx_w   = 32'(i_cmd.entry_index);
    assign tbl_we   = cmd_take && (i_cmd.kind == KIND_WRITE)
                      && (widx_w < 32'(P_TABLE_DEPTH));

    // Read address follows the sequencer; the registered read data arrives in the next cycle.
    always_comb begin
        case (r_state)
            S_PER_RD:            rd_addr = last_pt;
            S_WALK_RD, S_HI_RD:  rd_addr = seg_nx;
            default:             rd_addr = r_seg;
        endcase
    end

    pti_table #(.P_TABLE_DEPTH(P_TABLE_DEPTH)) u_table (
        .i_clk      (i_clk),
        .i_we       (tbl_we),
        .i_waddr    (widx_w[IW-1:0]),
        .i_wtime    (i_cmd.entry_time),
        .i_wvalue   (i_cmd.entry_value),
        .i_raddr    (rd_addr),
        .o_rd_time  (rd_time),
        .o_rd_value (rd_value)
    );

    pti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    // Signed differences for the interpolation; both magnitudes fit in 32 bits.
    logic [32:0] num_d, dv_d, num_n, dv_n;
    logic signed [35:0] vlo_x, q_x, sum_x;

    assign num_d = {1'b0, r_resid} - {1'b0, r_tlo};
    assign dv_d  = {r_vhi[31], r_vhi} - {r_vlo[31], r_vlo};
    assign num_n = 33'd0 - num_d;
    assign dv_n  = 33'd0 - dv_d;
    assign vlo_x = {{4{r_vlo[31]}}, r_vlo};
    assign q_x   = {1'b0, r_q};
    assign sum_x = r_neg ? (vlo_x - q_x) : (vlo_x + q_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_busy          <= 1'b0;
            r_done          <= 1'b0;
            r_seg           <= '0;
            r_points        <= POINTS_RESET;
            r_div_req.start <= 1'b0;
        end else begin
            r_done          <= 1'b0;
            r_div_req.start <= 1'b0;

            if (psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_IDX_POINTS)) begin
                r_points <= pwdata[4:0];
            end

            case (r_state)
                S_IDLE: begin
                    if (cmd_take && (i_cmd.kind == KIND_QUERY)) begin
                        r_busy    <= 1'b1;
                        r_elapsed <= i_cmd.elapsed_time;
                        // The kept segment is pulled back to the last segment in use.
                        if (r_seg > last_seg) begin
                            r_seg <= last_seg;
                        end
                        r_state <= S_PER_RD;
                    end
                end
                S_PER_RD: begin
                    r_state <= S_PER_CHK;
                end
                S_PER_CHK: begin
                    if (rd_time == 32'd0) begin
                        r_result.heat_load <= '0;
                        r_result.status    <= ST_ZERO_PERIOD;
                        r_result.segment   <= seg_w[3:0];
                        r_done             <= 1'b1;
                        r_busy             <= 1'b0;
                        r_state            <= S_IDLE;
                    end else begin
                        // Remainder of elapsed time by the period: 32 divider steps.
                        r_div_req.start    <= 1'b1;
                        r_div_req.long_op  <= 1'b0;
                        r_div_req.dividend <= {r_elapsed, 32'd0};
                        r_div_req.divisor  <= rd_time;
                        r_state            <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (div_rsp.done) begin
                        r_resid <= div_rsp.remainder;
                        r_state <= S_SEG_RD;
                    end
                end
                S_SEG_RD: begin
                    r_state <= S_SEG_CHK;
                end
                S_SEG_CHK: begin
                    // A residual below the kept segment restarts the search.
                    if (r_resid < rd_time) begin
                        r_seg <= '0;
                    end
                    r_state <= S_WALK_RD;
                end
                S_WALK_RD: begin
                    r_state <= (r_seg < last_seg) ? S_WALK_CHK : S_LO_RD;
                end
                S_WALK_CHK: begin
                    if (r_resid > rd_time) begin
                        r_seg   <= seg_nx;
                        r_state <= S_WALK_RD;
                    end else begin
                        r_state <= S_LO_RD;
                    end
                end
                S_LO_RD: begin
                    r_state <= S_HI_RD;
                end
                S_HI_RD: begin
                    r_tlo   <= rd_time;
                    r_vlo   <= rd_value;
                    r_state <= S_HI_CAP;
                end
                S_HI_CAP: begin
                    r_thi   <= rd_time;
                    r_vhi   <= rd_value;
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    if (r_thi <= r_tlo) begin
                        // Empty or descending segment: the lower value stands.
                        r_result.heat_load <= r_vlo;
                        r_result.status    <= ST_ZERO_SEGMENT;
                        r_result.segment   <= seg_w[3:0];
                        r_done             <= 1'b1;
                        r_busy             <= 1'b0;
                        r_state            <= S_IDLE;
                    end else begin
                        r_nmag  <= num_d[32] ? num_n[31:0] : num_d[31:0];
                        r_dmag  <= dv_d[32] ? dv_n[31:0] : dv_d[31:0];
                        r_neg   <= num_d[32] ^ dv_d[32];
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_nmag * r_dmag;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_div_req.start    <= 1'b1;
                    r_div_req.long_op  <= 1'b1;
                    r_div_req.dividend <= r_prod;
                    r_div_req.divisor  <= r_thi - r_tlo;
                    r_state            <= S_DIVW;
                end
                S_DIVW: begin
                    if (div_rsp.done) begin
                        r_q <= (div_rsp.quotient > 64'(Q_LIMIT)) ? Q_LIMIT
                                                                 : div_rsp.quotient[34:0];
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (sum_x > SAT_MAX) begin
                        r_result.heat_load <= 32'h7FFF_FFFF;
                    end else if (sum_x < SAT_MIN) begin
                        r_result.heat_load <= 32'h8000_0000;
                    end else begin
                        r_result.heat_load <= sum_x[31:0];
                    end
                    r_result.status  <= ST_OK;
                    r_result.segment <= seg_w[3:0];
                    r_done           <= 1'b1;
                    r_busy           <= 1'b0;
                    r_state          <= S_IDLE;
                end
                default: begin
                    r_busy  <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = r_busy;
    assign o_done   = r_done;
    assign o_result = r_result;
    assign pready   = 1'b1;
    assign prdata   = (paddr[ADDR_W-1:2] == REG_IDX_POINTS) ? 32'(r_points) : 32'd0;

    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still busy");

    a_seg_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_seg <= last_seg))
        else $error("segment index beyond the last segment during a query");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.kind == KIND_QUERY) |=> busy)
        else $error("query transfer did not raise busy");

    a_zero_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_ZERO_PERIOD) |-> (o_result.heat_load == 32'sd0))
        else $error("zero period must give a zero heat load");

endmodule

>>> sim/tb_periodic_table_interpolator_top.sv
// Self-checking testbench for the periodic table interpolator: random commands, scored results.
`timescale 1ns / 1ps

module tb_periodic_table_interpolator_top;

    import pti_pkg::*;

    // Saturation bounds of the interpolated heat load.
    localparam longint HEAT_MAX = 64'sd2147483647;
    localparam longint HEAT_MIN = -64'sd2147483648;
    localparam int unsigned PHASE_COUNT = 12;
    localparam int unsigned QUERIES_PER_PHASE = 102;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // Command side.
    logic     start = 1'b0;
    logic     busy;
    t_pti_in  i_cmd = '0;

    // Result side.
    logic     o_done;
    t_pti_out o_result;

    // Register port.
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    periodic_table_interpolator_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Commands waiting to be driven, and heat loads still owed by the block.
    t_pti_in  cmd_backlog [$];
    t_pti_out heat_due [$];
    int unsigned mismatch_cnt = 0;

    // Shadow of the block: breakpoint table, kept segment and point count.
    logic [31:0]        bp_time [TABLE_DEPTH];
    logic signed [31:0] bp_value [TABLE_DEPTH];
    int unsigned        kept_seg = 0;
    logic [4:0]         points_cfg = POINTS_RESET;

    // Stimulus planning state: the times the generator has written so far, the
    // point count it plans for, and a running clock for monotonic queries.
    logic [31:0] plan_time [TABLE_DEPTH];
    logic [4:0]  plan_points = POINTS_RESET;
    logic [31:0] run_clock = '0;
    bit          no_gaps = 1'b0;

    // The point count in use is clamped to 2..TABLE_DEPTH whatever the register holds.
    function automatic int unsigned points_live(input logic [4:0] cfg);
        if (cfg < 2) return 2;
        if (cfg > TABLE_DEPTH) return TABLE_DEPTH;
        return cfg;
    endfunction

    // Applies one accepted command to the shadow and returns 1 with the
    // expected result when the command is a query.
    function automatic bit interpolate_heat(input t_pti_in c, output t_pti_out r);
        int unsigned live, last_seg, seg;
        logic [31:0] period, residual, t_lo, t_hi, span;
        longint      v_lo, v_hi, num, dv, res;
        logic [63:0] num_mag, dv_mag, q;
        bit          neg;
        r = '0;
        if (c.kind == KIND_WRITE) begin
            bp_time[c.entry_index]  = c.entry_time;
            bp_value[c.entry_index] = c.entry_value;
            return 1'b0;
        end
        live     = points_live(points_cfg);
        last_seg = live - 2;
        // The kept index is pulled back into range before the period check.
        if (kept_seg > last_seg) kept_seg = last_seg;
        period = bp_time[live - 1];
        if (period == 0) begin
            r.heat_load = '0;
            r.status    = ST_ZERO_PERIOD;
            r.segment   = kept_seg[3:0];
            return 1'b1;
        end
        residual = c.elapsed_time % period;
        // A residual below the kept segment restarts the search from the front.
        seg = kept_seg;
        if (residual < bp_time[seg]) seg = 0;
        while (seg < last_seg && residual > bp_time[seg + 1]) seg++;
        kept_seg  = seg;
        t_lo      = bp_time[seg];
        t_hi      = bp_time[seg + 1];
        v_lo      = longint'(bp_value[seg]);
        v_hi      = longint'(bp_value[seg + 1]);
        r.segment = seg[3:0];
        if (t_hi <= t_lo) begin
            r.heat_load = bp_value[seg];
            r.status    = ST_ZERO_SEGMENT;
            return 1'b1;
        end
        num     = longint'(residual) - longint'(t_lo);
        dv      = v_hi - v_lo;
        neg     = (num < 0) != (dv < 0);
        num_mag = (num < 0) ? -num : num;
        dv_mag  = (dv < 0) ? -dv : dv;
        span    = t_hi - t_lo;
        // Truncating division of magnitudes, then the step clamp at 2^34.
        q = (num_mag * dv_mag) / {32'd0, span};
        if (q > 64'h4_0000_0000) q = 64'h4_0000_0000;
        res = neg ? v_lo - longint'(q) : v_lo + longint'(q);
        if (res > HEAT_MAX) res = HEAT_MAX;
        if (res < HEAT_MIN) res = HEAT_MIN;
        r.heat_load = res[31:0];
        r.status    = ST_OK;
        return 1'b1;
    endfunction

    // Idle cycles before the next command: mostly none or short, a few long.
    function automatic int unsigned idle_gap();
        int unsigned r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Command driver. A command transfers at an edge where start is high and
    // busy is low; the shadow is updated at that same edge, so its order matches
    // the block's order of acceptance. start stays high across back-to-back
    // transfers, and each signal gets at most one assignment per edge.
    int unsigned gap_left = 0;

    always @(posedge i_clk) begin : drive_cmd
        t_pti_out res;
        if (!i_rst_n) begin
            start    <= 1'b0;
            i_cmd    <= '0;
            gap_left <= 0;
        end else begin
            if (start && !busy) begin
                if (interpolate_heat(i_cmd, res)) heat_due.push_back(res);
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    start    <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    i_cmd    <= cmd_backlog.pop_front();
                    start    <= 1'b1;
                    gap_left <= idle_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic note_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("%t mismatch: %s", $realtime, what);
    endtask

    // Result monitor. Each result is valid for exactly one cycle on o_done and
    // is scored against the oldest outstanding expectation.
    always @(posedge i_clk) begin : watch_result
        t_pti_out want;
        if (i_rst_n && o_done) begin
            if (heat_due.size() == 0) begin
                note_mismatch($sformatf("unexpected result heat_load=%0d status=%0d segment=%0d",
                                        o_result.heat_load, o_result.status, o_result.segment));
            end else begin
                want = heat_due.pop_front();
                if (o_result.heat_load !== want.heat_load || o_result.status !== want.status ||
                    o_result.segment !== want.segment) begin
                    note_mismatch($sformatf(
                        "expected heat_load=%0d status=%0d segment=%0d, got %0d %0d %0d",
                        want.heat_load, want.status, want.segment,
                        o_result.heat_load, o_result.status, o_result.segment));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------

    task automatic queue_write(input logic [3:0] idx, input logic [31:0] t,
                               input logic [31:0] v);
        t_pti_in c;
        c.kind         = KIND_WRITE;
        c.entry_index  = idx;
        c.entry_time   = t;
        c.entry_value  = v;
        c.elapsed_time = $urandom;
        cmd_backlog.push_back(c);
        plan_time[idx] = t;
    endtask

    // The table fields of a query are ignored by the block, so they carry noise.
    task automatic queue_query(input logic [31:0] elapsed);
        t_pti_in c;
        c.kind         = KIND_QUERY;
        c.entry_index  = $urandom;
        c.entry_time   = $urandom;
        c.entry_value  = $urandom;
        c.elapsed_time = elapsed;
        cmd_backlog.push_back(c);
    endtask

    function automatic logic [31:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (r < 40) return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
        return $urandom;
    endfunction

    // Elapsed times: a monotonic clock that walks the segments forward, hits
    // right on and beside breakpoints, full-range noise and the extremes.
    function automatic logic [31:0] pick_elapsed();
        int unsigned live, r, j;
        logic [31:0] period, k;
        live   = points_live(plan_points);
        period = plan_time[live - 1];
        r      = $urandom_range(0, 99);
        if (r < 40) begin
            if (period == 0) run_clock += $urandom_range(1, 100);
            else run_clock += $urandom_range(1, period / 6 + 1);
            return run_clock;
        end
        if (r < 65) begin
            j = $urandom_range(0, live - 1);
            k = $urandom_range(0, 3);
            return k * period + plan_time[j] + $urandom_range(0, 2) - 32'd1;
        end
        if (r < 85) return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return period - 32'd1;
            default: return period;
        endcase
    endfunction

    // Loads all sixteen slots in a rotated order. Modes: 0 ascending with short
    // segments, 1 ascending across the whole time range, 2 ascending with
    // zero-length segments, 3 unordered times, 4 ascending with a zero period.
    task automatic queue_table(input int unsigned mode);
        logic [31:0] tt [TABLE_DEPTH];
        logic [31:0] t, step_max;
        int unsigned rot, idx;
        step_max = (mode == 1) ? 32'h0FFF_FFFF : 32'd200;
        t   = $urandom_range(0, 1) ? 32'd0 : $urandom_range(0, step_max);
        rot = $urandom_range(0, TABLE_DEPTH - 1);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (mode == 3) begin
                tt[i] = $urandom;
            end else begin
                tt[i] = t;
                if (mode == 2 && $urandom_range(0, 2) == 0) t = t;
                else t = t + $urandom_range(1, step_max);
            end
        end
        if (mode == 4) tt[points_live(plan_points) - 1] = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            idx = (i + rot) % TABLE_DEPTH;
            queue_write(idx[3:0], tt[idx], pick_value());
        end
    endtask

    // Waits until every command has transferred and every result has come back.
    task automatic settle();
        do @(negedge i_clk);
        while (cmd_backlog.size() != 0 || start || busy || heat_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // Register write: setup cycle, then access until pready completes it.
    task automatic write_points(input logic [4:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_IDX_POINTS, 2'b00};
        pwdata  <= {27'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        points_cfg = value;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin : run_test
        logic [4:0]  cfg_seq [PHASE_COUNT];
        int unsigned mode, idx;
        cfg_seq = '{5'd16, 5'd5, 5'd0, 5'd31, 5'd1, 5'd17, 5'd9, 5'd2, 5'd16, 5'd3,
                    5'd12, 5'd24};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset point count of two. Every slot is written
        // before the first query so no query reads an unwritten entry. The first
        // segment runs from 500 to 1000 with full-scale opposite values, so
        // queries below 500 extrapolate far enough to saturate.
        @(negedge i_clk);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            queue_write(i[3:0], 32'd500 + 32'd500 * i,
                        (i == 0) ? 32'h7FFF_FFFF :
                        (i == 1) ? 32'h8000_0000 : (i[0] ? -32'sd65536 * i : 32'sd65536 * i));
        end
        queue_query(32'd0);             // below the first time, saturates high
        queue_query(32'd750);           // inside the segment
        queue_query(32'd500);           // exactly on the lower breakpoint
        queue_query(32'hFFFF_FFFF);     // largest elapsed time
        queue_write(4'd0, 32'd500, 32'h8000_0000);
        queue_write(4'd1, 32'd1000, 32'h7FFF_FFFF);
        queue_query(32'd1000);          // wraps to zero, saturates low
        queue_write(4'd1, 32'd500, 32'h7FFF_FFFF);
        queue_query(32'd1234);          // zero-length segment
        queue_write(4'd1, 32'd200, 32'h0001_0000);
        queue_query(32'd150);           // descending segment
        queue_write(4'd1, 32'd0, 32'h0001_0000);
        queue_query(32'd77);            // zero period

        // Random phases, each with its own point count and table shape. A few
        // phases run without idle cycles so that transfers go back to back.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            settle();
            write_points(cfg_seq[ph]);
            plan_points = cfg_seq[ph];
            no_gaps     = (ph % 3 == 2);
            mode        = (ph == 4) ? 4 : ph % 4;
            run_clock   = $urandom_range(0, 1) ? 32'd0 : $urandom;
            queue_table(mode);
            repeat (QUERIES_PER_PHASE) begin
                if ($urandom_range(0, 99) < 6) begin
                    // Half are value updates at the same time, the other half
                    // a new time that may break the ordering of the table.
                    idx = $urandom_range(0, TABLE_DEPTH - 1);
                    queue_write(idx[3:0], $urandom_range(0, 1) ? plan_time[idx] : $urandom,
                                pick_value());
                end else begin
                    queue_query(pick_elapsed());
                end
            end
        end

        // Drain, then leave room for any stray result after the last one.
        settle();
        repeat (200) @(negedge i_clk);
        if (mismatch_cnt == 0 && heat_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin : watchdog
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
sv/pti_pkg.sv
sv/pti_table.sv
sv/pti_div.sv
sv/periodic_table_interpolator_top.sv
sim/tb_periodic_table_interpolator_top.sv
